[rtl/chtik_pkg.sv]
// chtik_pkg: shared types and codes for the chained hash table
// no dependencies
package chtik_pkg;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_GET     = 2'd2,
		REQ_REPLACE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_LEN,
		S_CHK,
		S_RD,
		S_CMP,
		S_ACT,
		S_SHRD,
		S_SHWR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

[rtl/chtik_mod.sv]
// chtik_mod: bit-serial 64-bit by 9-bit remainder unit, one quotient bit per cycle
// depends on chtik_pkg
module chtik_mod import chtik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [8:0]  divisor,
	output div_ctl_t    ctl,
	output logic [8:0]  remainder
);

	logic [63:0] num_q;
	logic [9:0]  rem_q;
	logic [8:0]  div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [9:0]  trial;

	assign trial = {rem_q[8:0], num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
			else                        rem_q <= trial;
		end
	end

	assign remainder = rem_q[8:0];
	assign ctl = '{start: start, busy: busy_q, done: done_q};

endmodule

[rtl/chained_hash_table_int_keys.sv]
// chained hash table with 64-bit keys: iterative modulo then a serial chain scan
// result word follows the input word via the modulo, the chain length read and check,
// a read and compare per slot scanned, the update, and a read and write per shift on remove
// one word at a time; the next word is taken the cycle after the result word is delivered
// arst_n clears chain lengths and sets bcnt_q to min(BUCKETS,256); slots are undefined
// depends on chtik_pkg and chtik_mod
module chained_hash_table_int_keys import chtik_pkg::*; #(
	parameter int BUCKETS   = 256,
	parameter int CHAIN_MAX = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] key,
	input  logic [63:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] read_value
);

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LW    = $clog2(CHAIN_MAX + 1);
	localparam int SLOTS = BUCKETS * CHAIN_MAX;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BMAX  = (BUCKETS < 256) ? BUCKETS : 256;

	state_t state_q, state_d;
	logic [8:0]    bcnt_q;
	logic [1:0]    type_q;
	logic [63:0]   key_q, wval_q, rdk_q, rdv_q;
	logic [BW-1:0] bucket_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] j_q;
	logic [1:0]    stat_q;
	logic [63:0]   rval_q;
	logic          hit_q;
	logic [LW-1:0] chain_len [BUCKETS];
	logic [63:0]   mem_k [SLOTS];
	logic [63:0]   mem_v [SLOTS];
	div_ctl_t      dctl;
	logic [8:0]    rem;
	logic [8:0]    cfg_clip;
	logic          mem_we, key_we;
	logic [63:0]   wk, wv;
	logic [LW-1:0] waddr_j;

	always_comb begin
		cfg_clip = (cfg_wdata == 9'd0) ? 9'd1 : cfg_wdata;
		if ({23'd0, cfg_clip} > BUCKETS) cfg_clip = 9'(BUCKETS);
	end

	chtik_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_IDLE && in_valid),
		.dividend(key), .divisor(bcnt_q), .ctl(dctl), .remainder(rem)
	);

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign status     = stat_q;
	assign read_value = rval_q;

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		key_we  = 1'b0;
		wk      = key_q;
		wv      = wval_q;
		waddr_j = j_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DIV;
			S_DIV:  if (dctl.done) state_d = S_LEN;
			S_LEN:  state_d = S_CHK;
			S_CHK:  state_d = (len_q == 0) ? S_ACT : S_RD;
			S_RD:   state_d = S_CMP;
			S_CMP: begin
				if (rdk_q == key_q || j_q + 1'b1 == len_q) state_d = S_ACT;
				else state_d = S_RD;
			end
			S_ACT: begin
				state_d = S_OUT;
				case (req_t'(type_q))
					REQ_INSERT: if (!hit_q && len_q < LW'(CHAIN_MAX)) begin
						mem_we = 1'b1; key_we = 1'b1; waddr_j = len_q;
					end
					REQ_REMOVE: if (hit_q && j_q + 1'b1 < len_q) state_d = S_SHRD;
					REQ_REPLACE: if (hit_q) mem_we = 1'b1;
					default: ;
				endcase
			end
			S_SHRD: state_d = S_SHWR;
			S_SHWR: begin
				mem_we = 1'b1; key_we = 1'b1; wk = rdk_q; wv = rdv_q;
				state_d = (j_q + 2'd2 < len_q) ? S_SHRD : S_OUT;
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bcnt_q  <= 9'(BMAX);
			for (int i = 0; i < BUCKETS; i++) chain_len[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) bcnt_q <= cfg_clip;
			if (state_q == S_ACT) begin
				if (type_q == REQ_INSERT && !hit_q && len_q < LW'(CHAIN_MAX))
					chain_len[bucket_q] <= len_q + 1'b1;
				if (type_q == REQ_REMOVE && hit_q)
					chain_len[bucket_q] <= len_q - 1'b1;
			end
		end
	end

	// slot address of bucket, entry
	function automatic logic [AW-1:0] slot(input logic [BW-1:0] b, input logic [LW-1:0] e);
		slot = AW'(b) * AW'(CHAIN_MAX) + AW'(e);
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			type_q <= req_type;
			key_q  <= key;
			wval_q <= write_value;
		end
		if (dctl.done) bucket_q <= ({23'd0, rem} >= BUCKETS) ? BW'(BUCKETS - 1) : BW'(rem);
		case (state_q)
			S_LEN: begin
				len_q <= chain_len[bucket_q];
				j_q   <= '0;
				hit_q <= 1'b0;
			end
			S_RD: begin
				rdk_q <= mem_k[slot(bucket_q, j_q)];
				rdv_q <= mem_v[slot(bucket_q, j_q)];
			end
			S_CMP: begin
				if (rdk_q == key_q) hit_q <= 1'b1;
				else if (j_q + 1'b1 != len_q) j_q <= j_q + 1'b1;
			end
			S_ACT: begin
				rval_q <= '0;
				stat_q <= ST_DONE;
				case (req_t'(type_q))
					REQ_INSERT: if (!hit_q && len_q >= LW'(CHAIN_MAX)) stat_q <= ST_FULL;
					REQ_GET: if (hit_q) rval_q <= rdv_q; else stat_q <= ST_NOTFOUND;
					default: if (!hit_q) stat_q <= ST_NOTFOUND;
				endcase
			end
			S_SHRD: begin
				rdk_q <= mem_k[slot(bucket_q, j_q + 1'b1)];
				rdv_q <= mem_v[slot(bucket_q, j_q + 1'b1)];
			end
			S_SHWR: j_q <= j_q + 1'b1;
			default: ;
		endcase
		if (mem_we) begin
			mem_v[slot(bucket_q, waddr_j)] <= wv;
			if (key_we) mem_k[slot(bucket_q, waddr_j)] <= wk;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value))
		else $error("result word changed while stalled");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> len_q <= LW'(CHAIN_MAX) && j_q < len_q)
		else $error("scan index out of chain");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");

endmodule

[test/chained_hash_table_int_keys_tb.sv]
// chained_hash_table_int_keys_tb: randomized self-checking bench for the chained hash table
// predicts status and read value per request against a local table model
// depends on chtik_pkg and chained_hash_table_int_keys
module chained_hash_table_int_keys_tb import chtik_pkg::*;;

	localparam int BUCKETS   = 256;
	localparam int CHAIN_MAX = 4;
	localparam int N_RANDOM  = 1830;

	typedef struct {
		status_t     st;
		logic [63:0] val;
	} reply_t;

	class table_scoreboard;
		int unsigned  divisor;
		int unsigned  chain_len[BUCKETS];
		logic [63:0]  chain_key[BUCKETS][CHAIN_MAX];
		logic [63:0]  chain_val[BUCKETS][CHAIN_MAX];
		reply_t       pending[$];
		int           errors;

		function void clear();
			divisor = BUCKETS;
			foreach (chain_len[b]) chain_len[b] = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void set_divisor(logic [8:0] v);
			if (v == 0) divisor = 1;
			else if (v > BUCKETS) divisor = BUCKETS;
			else divisor = v;
		endfunction

		function void note_request(req_t kind, logic [63:0] k, logic [63:0] wv);
			int unsigned b, n, hit;
			reply_t r;
			b = k % divisor;
			n = chain_len[b];
			hit = n;
			for (int j = n - 1; j >= 0; j--)
				if (chain_key[b][j] == k) hit = j;
			r.val = '0;
			r.st = ST_DONE;
			case (kind)
				REQ_INSERT: begin
					if (hit == n) begin
						if (n >= CHAIN_MAX) r.st = ST_FULL;
						else begin
							chain_key[b][n] = k;
							chain_val[b][n] = wv;
							chain_len[b] = n + 1;
						end
					end
				end
				REQ_REMOVE: begin
					if (hit == n) r.st = ST_NOTFOUND;
					else begin
						for (int j = hit; j + 1 < n; j++) begin
							chain_key[b][j] = chain_key[b][j+1];
							chain_val[b][j] = chain_val[b][j+1];
						end
						chain_len[b] = n - 1;
					end
				end
				REQ_GET: begin
					if (hit == n) r.st = ST_NOTFOUND;
					else r.val = chain_val[b][hit];
				end
				default: begin
					if (hit == n) r.st = ST_NOTFOUND;
					else chain_val[b][hit] = wv;
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic [63:0] val);
			reply_t r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: status %0d value %h", st, val);
				return;
			end
			r = pending.pop_front();
			if (st !== r.st || val !== r.val) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: status exp %0d got %0d, value exp %h got %h",
						r.st, st, r.val, val);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [8:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [63:0] key;
	logic [63:0] write_value;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [63:0] read_value;

	table_scoreboard sb;
	int  hold_cycles = 0;
	bit  hold_req;
	logic [63:0] key_pool[16];

	chained_hash_table_int_keys #(.BUCKETS(BUCKETS), .CHAIN_MAX(CHAIN_MAX)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .key(key),
		.write_value(write_value), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_value(read_value)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// result side: stall pattern plus long hold-off on request
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_reply(status, read_value);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_cycles <= 400;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	task automatic send_word(req_t kind, logic [63:0] k, logic [63:0] wv);
		in_valid <= 1'b1;
		req_type <= kind;
		key <= k;
		write_value <= wv;
		do @(posedge clk); while (in_stall);
		sb.note_request(kind, k, wv);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_divisor(logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_divisor(v);
	endtask

	task automatic random_phase(int count, int pool_span);
		int burst;
		int gap;
		logic [63:0] k;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 20);
			end
			burst--;
			if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_span)];
			else k = {$urandom, $urandom};
			send_word(req_t'($urandom_range(0, 3)), k, {$urandom, $urandom});
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		key = '0;
		write_value = '0;
		hold_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one bucket, extremes, full chain, missing keys, order after remove
		write_divisor(9'd1);
		send_word(REQ_GET, 64'd0, '1);
		send_word(REQ_REMOVE, '1, '0);
		send_word(REQ_REPLACE, 64'd5, '1);
		send_word(REQ_INSERT, 64'd0, '1);
		send_word(REQ_INSERT, '1, 64'd0);
		send_word(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h5555_aaaa_5555_aaaa);
		send_word(REQ_INSERT, 64'd0, 64'd7);
		send_word(REQ_INSERT, 64'd42, 64'haaaa_5555_aaaa_5555);
		send_word(REQ_INSERT, 64'd43, 64'd1);
		send_word(REQ_GET, 64'd0, '0);
		send_word(REQ_REMOVE, '1, '0);
		send_word(REQ_GET, 64'd42, '0);
		send_word(REQ_REPLACE, 64'd42, 64'd99);
		send_word(REQ_GET, 64'd42, '0);
		send_word(REQ_INSERT, 64'd43, 64'd2);
		send_word(REQ_GET, 64'd43, '0);
		send_word(REQ_REMOVE, 64'd0, '0);
		send_word(REQ_GET, 64'h8000_0000_0000_0000, '0);
		drain();

		write_divisor(9'd0);
		send_word(REQ_GET, 64'd42, '0);
		drain();
		write_divisor(9'h1ff);
		send_word(REQ_INSERT, 64'd255, '1);
		send_word(REQ_GET, 64'd255, '0);
		drain();

		// random phases over several divisors
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_divisor(9'd256);
				1: write_divisor(9'd1);
				2: write_divisor(9'd3);
				3: write_divisor(9'($urandom_range(2, 255)));
				4: write_divisor(9'($urandom_range(257, 511)));
				default: write_divisor(9'd7);
			endcase
			foreach (key_pool[i])
				key_pool[i] = ($urandom_range(0, 1)) ? {$urandom, $urandom}
					: 64'($urandom_range(0, 40));
			if (p == 2) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			random_phase(N_RANDOM / 6, (p == 1) ? 6 : 15);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
